[src/adaptive_compass_search_top_defines.svh]
// Assertion macros for the checker file of the compass search block
`ifndef ADAPTIVE_COMPASS_SEARCH_TOP_DEFINES_SVH
`define ADAPTIVE_COMPASS_SEARCH_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low
`define ACS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low
`define ACS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/acs_pkg.sv]
package acs_pkg;

  // Number format and counter sizes
  localparam int VALUE_WIDTH       = 32;
  localparam int FRACTION_BITS     = 16;
  localparam int ROUND_COUNT_WIDTH = 20;

  // Step is a non-negative value, one bit narrower than a signed value
  localparam int STEP_WIDTH = VALUE_WIDTH - 1;
  localparam int CFG_WIDTH  = (STEP_WIDTH > ROUND_COUNT_WIDTH) ? STEP_WIDTH
                                                               : ROUND_COUNT_WIDTH;
  localparam int CFG_INDEX_W = 2;

  // Stream word sizes, padded to whole bytes
  localparam int IN_DATA_BITS  = 3 * VALUE_WIDTH;
  localparam int IN_DATA_W     = ((IN_DATA_BITS + 7) / 8) * 8;
  localparam int CAUSE_LSB     = 3 * VALUE_WIDTH + ROUND_COUNT_WIDTH;
  localparam int OUT_DATA_BITS = CAUSE_LSB + 2;
  localparam int OUT_DATA_W    = ((OUT_DATA_BITS + 7) / 8) * 8;

  localparam logic signed [VALUE_WIDTH-1:0] VALUE_MAX = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
  localparam logic signed [VALUE_WIDTH-1:0] VALUE_MIN = {1'b1, {(VALUE_WIDTH-1){1'b0}}};

  // Reset values of the registers: initial step is 0.01 in fixed point
  localparam logic [STEP_WIDTH-1:0] INIT_STEP_RESET =
    STEP_WIDTH'((64'd1 << FRACTION_BITS) / 64'd100);
  localparam logic [STEP_WIDTH-1:0] MIN_STEP_RESET  = STEP_WIDTH'(1);
  localparam logic [STEP_WIDTH-1:0] TOLERANCE_RESET = STEP_WIDTH'(1);
  localparam logic [ROUND_COUNT_WIDTH-1:0] LIMIT_RESET = ROUND_COUNT_WIDTH'(500000);

  // Reciprocal of ten: floor(s * STEP_RECIP >> (STEP_WIDTH+4)) == s / 10
  localparam logic [STEP_WIDTH+4:0] RECIP_POW  = {1'b1, {(STEP_WIDTH+4){1'b0}}};
  localparam logic [STEP_WIDTH+4:0] RECIP_FULL =
    (RECIP_POW + (STEP_WIDTH+5)'(9)) / (STEP_WIDTH+5)'(10);
  localparam logic [STEP_WIDTH:0] STEP_RECIP = RECIP_FULL[STEP_WIDTH:0];

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_INITIAL_STEP    = 2'd0,
    REG_MINIMUM_STEP    = 2'd1,
    REG_VALUE_TOLERANCE = 2'd2,
    REG_ITERATION_LIMIT = 2'd3
  } cfg_reg_t;

  typedef enum logic {
    ACT_START = 1'b0,
    ACT_REPLY = 1'b1
  } action_t;

  typedef enum logic [1:0] {
    KIND_EVAL    = 2'd0,
    KIND_DONE    = 2'd1,
    KIND_IGNORED = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    CAUSE_RUN         = 2'd0,
    CAUSE_MIN_STEP    = 2'd1,
    CAUSE_TOLERANCE   = 2'd2,
    CAUSE_ROUND_LIMIT = 2'd3
  } cause_t;

  typedef struct packed {
    logic [STEP_WIDTH-1:0]        start_step;
    logic [STEP_WIDTH-1:0]        minimum_step;
    logic [STEP_WIDTH-1:0]        value_tolerance;
    logic [ROUND_COUNT_WIDTH-1:0] iteration_limit;
  } cfg_t;

  typedef struct packed {
    action_t                        action;
    logic signed [VALUE_WIDTH-1:0]  start_x;
    logic signed [VALUE_WIDTH-1:0]  start_y;
    logic signed [VALUE_WIDTH-1:0]  objective_value;
  } in_item_t;

  typedef struct packed {
    kind_t                          result_kind;
    logic signed [VALUE_WIDTH-1:0]  point_x;
    logic signed [VALUE_WIDTH-1:0]  point_y;
    logic signed [VALUE_WIDTH-1:0]  best_value;
    logic [ROUND_COUNT_WIDTH-1:0]   rounds_done;
    cause_t                         stop_cause;
  } out_item_t;

endpackage

[src/adaptive_compass_search_top.sv]
// Compass search sequencer for a two-coordinate minimization whose objective
// is evaluated outside: a start word (tuser 0) loads the start point and every
// reply word (tuser 1) carries the objective at the last requested point; each
// input word yields exactly one output word (evaluate request, finished with
// the best point and stop cause, or reply ignored while idle). The block takes
// one word per clock unless the result side is stalled; an accepted word sits
// in the input register while one pass of compare, saturating add and step
// update fills the result register. The grown step (step * 1.1) comes from a
// constant-reciprocal multiplier registered behind the step register. Write
// the configuration registers only while no search word is in flight.
module adaptive_compass_search_top (
  input  logic                           clk,
  input  logic                           rst_n,
  // input stream
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [acs_pkg::IN_DATA_W-1:0]  in_tdata,  // start_x, start_y, objective_value
  input  logic                           in_tuser,  // action
  // result stream
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // point_x, point_y, best_value, rounds_done, stop_cause, zero pad
  output logic [acs_pkg::OUT_DATA_W-1:0] out_tdata,
  output logic [1:0]                     out_tuser, // result_kind
  // configuration writes
  input  logic                           cfg_we,
  input  logic [acs_pkg::CFG_INDEX_W-1:0] cfg_addr,
  input  logic [acs_pkg::CFG_WIDTH-1:0]  cfg_wdata
);

  acs_pkg::cfg_t      cfg_r, cfg_nxt;
  logic               item_valid;
  acs_pkg::in_item_t  item;
  logic               take;
  acs_pkg::out_item_t res;

  // Configuration register writes
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (acs_pkg::cfg_reg_t'(cfg_addr))
        acs_pkg::REG_INITIAL_STEP:
          cfg_nxt.start_step      = cfg_wdata[acs_pkg::STEP_WIDTH-1:0];
        acs_pkg::REG_MINIMUM_STEP:
          cfg_nxt.minimum_step    = cfg_wdata[acs_pkg::STEP_WIDTH-1:0];
        acs_pkg::REG_VALUE_TOLERANCE:
          cfg_nxt.value_tolerance = cfg_wdata[acs_pkg::STEP_WIDTH-1:0];
        acs_pkg::REG_ITERATION_LIMIT:
          cfg_nxt.iteration_limit = cfg_wdata[acs_pkg::ROUND_COUNT_WIDTH-1:0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.start_step      <= acs_pkg::INIT_STEP_RESET;
      cfg_r.minimum_step    <= acs_pkg::MIN_STEP_RESET;
      cfg_r.value_tolerance <= acs_pkg::TOLERANCE_RESET;
      cfg_r.iteration_limit <= acs_pkg::LIMIT_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  acs_in_stage u_in_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .take       (take),
    .item_valid (item_valid),
    .item       (item)
  );

  acs_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_valid  (item_valid),
    .in_item   (item),
    .in_take   (take),
    .out_ready (out_tready),
    .out_valid (out_tvalid),
    .out_item  (res)
  );

  // Pack the result word, first field in the lowest bits
  assign out_tdata = acs_pkg::OUT_DATA_W'({res.stop_cause, res.rounds_done,
                                           res.best_value, res.point_y, res.point_x});
  assign out_tuser = res.result_kind;

endmodule

[src/acs_step_scale.sv]
// Grown step: step + round(step / 10), ties up, saturated.
// Registered; follows the step register, updating in the cycle after it.
module acs_step_scale (
  input  logic                           clk,
  input  logic [acs_pkg::STEP_WIDTH-1:0] step,
  output logic [acs_pkg::STEP_WIDTH-1:0] step_up_r
);

  logic [2*acs_pkg::STEP_WIDTH:0]  prod;
  logic [acs_pkg::STEP_WIDTH-4:0]  quot;
  logic [acs_pkg::STEP_WIDTH-1:0]  quot_ext;
  logic [acs_pkg::STEP_WIDTH-1:0]  quot_x10;
  logic [acs_pkg::STEP_WIDTH-1:0]  rem;
  logic                            round_up;
  logic [acs_pkg::STEP_WIDTH-1:0]  inc;
  logic [acs_pkg::STEP_WIDTH:0]    sum;
  logic [acs_pkg::STEP_WIDTH-1:0]  step_up_nxt;

  // Divide by ten through the reciprocal, then fix up the rounding
  always_comb begin
    prod = {{(acs_pkg::STEP_WIDTH+1){1'b0}}, step} *
           {{acs_pkg::STEP_WIDTH{1'b0}}, acs_pkg::STEP_RECIP};
    quot     = prod[2*acs_pkg::STEP_WIDTH:acs_pkg::STEP_WIDTH+4];
    quot_ext = {3'b000, quot};
    quot_x10 = (quot_ext << 3) + (quot_ext << 1);
    rem      = step - quot_x10;
    round_up = (rem >= acs_pkg::STEP_WIDTH'(5));
    inc      = quot_ext + acs_pkg::STEP_WIDTH'(round_up);
    sum      = {1'b0, step} + {1'b0, inc};
    step_up_nxt = sum[acs_pkg::STEP_WIDTH] ? {acs_pkg::STEP_WIDTH{1'b1}}
                                           : sum[acs_pkg::STEP_WIDTH-1:0];
  end

  always_ff @(posedge clk) begin
    step_up_r <= step_up_nxt;
  end

endmodule

[src/acs_in_stage.sv]
// Input register: holds one accepted word until the core takes it
module acs_in_stage (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [acs_pkg::IN_DATA_W-1:0] in_tdata,
  input  logic                          in_tuser,
  input  logic                          take,
  output logic                          item_valid,
  output acs_pkg::in_item_t             item
);

  logic              valid_r, valid_nxt;
  acs_pkg::in_item_t item_r, item_nxt;
  logic              accept;

  assign in_tready = !valid_r || take;
  assign accept    = in_tvalid && in_tready;

  // Unpack the word, first field in the lowest bits
  always_comb begin
    item_nxt = item_r;
    if (accept) begin
      item_nxt.action          = acs_pkg::action_t'(in_tuser);
      item_nxt.start_x         = in_tdata[acs_pkg::VALUE_WIDTH-1:0];
      item_nxt.start_y         = in_tdata[2*acs_pkg::VALUE_WIDTH-1:acs_pkg::VALUE_WIDTH];
      item_nxt.objective_value =
        in_tdata[3*acs_pkg::VALUE_WIDTH-1:2*acs_pkg::VALUE_WIDTH];
    end
    valid_nxt = accept ? 1'b1 : (take ? 1'b0 : valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    item_r <= item_nxt;
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule

[src/acs_core.sv]
// Search sequencer: one pass per word from the input register into the
// result register, with the search state updated in the same cycle.
module acs_core (
  input  logic               clk,
  input  logic               rst_n,
  input  acs_pkg::cfg_t      cfg,
  input  logic               in_valid,
  input  acs_pkg::in_item_t  in_item,
  output logic               in_take,
  input  logic               out_ready,
  output logic               out_valid,
  output acs_pkg::out_item_t out_item
);

  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_START = 3'd1,
    PH_XP    = 3'd2,
    PH_XM    = 3'd3,
    PH_YP    = 3'd4,
    PH_YM    = 3'd5
  } phase_t;

  function automatic logic signed [acs_pkg::VALUE_WIDTH-1:0] sat_add(
    input logic signed [acs_pkg::VALUE_WIDTH-1:0] a,
    input logic [acs_pkg::STEP_WIDTH-1:0]         s
  );
    logic signed [acs_pkg::VALUE_WIDTH:0] sum;
    sum = {a[acs_pkg::VALUE_WIDTH-1], a} + $signed({2'b00, s});
    return (sum[acs_pkg::VALUE_WIDTH] != sum[acs_pkg::VALUE_WIDTH-1]) ?
           acs_pkg::VALUE_MAX : sum[acs_pkg::VALUE_WIDTH-1:0];
  endfunction

  function automatic logic signed [acs_pkg::VALUE_WIDTH-1:0] sat_sub(
    input logic signed [acs_pkg::VALUE_WIDTH-1:0] a,
    input logic [acs_pkg::STEP_WIDTH-1:0]         s
  );
    logic signed [acs_pkg::VALUE_WIDTH:0] dif;
    dif = {a[acs_pkg::VALUE_WIDTH-1], a} - $signed({2'b00, s});
    return (dif[acs_pkg::VALUE_WIDTH] != dif[acs_pkg::VALUE_WIDTH-1]) ?
           acs_pkg::VALUE_MIN : dif[acs_pkg::VALUE_WIDTH-1:0];
  endfunction

  // State registers
  phase_t                                  phase_r, phase_nxt;
  logic signed [acs_pkg::VALUE_WIDTH-1:0]  best_x_r, best_x_nxt;
  logic signed [acs_pkg::VALUE_WIDTH-1:0]  best_y_r, best_y_nxt;
  logic signed [acs_pkg::VALUE_WIDTH-1:0]  best_val_r, best_val_nxt;
  logic signed [acs_pkg::VALUE_WIDTH-1:0]  prior_r, prior_nxt;
  logic signed [acs_pkg::VALUE_WIDTH-1:0]  trial_x_r, trial_x_nxt;
  logic signed [acs_pkg::VALUE_WIDTH-1:0]  trial_y_r, trial_y_nxt;
  logic [acs_pkg::STEP_WIDTH-1:0]          step_r, step_nxt;
  logic [acs_pkg::ROUND_COUNT_WIDTH-1:0]   rounds_r, rounds_nxt;
  logic                                    improved_r, improved_nxt;
  logic                                    out_valid_r, out_valid_nxt;
  acs_pkg::out_item_t                      out_item_r, out_item_nxt;

  // Trial outcome and end-of-round terms
  logic [acs_pkg::STEP_WIDTH-1:0]          step_up;
  logic signed [acs_pkg::VALUE_WIDTH-1:0]  v;
  logic                                    better;
  logic signed [acs_pkg::VALUE_WIDTH-1:0]  bx_after, by_after;
  logic signed [acs_pkg::VALUE_WIDTH-1:0]  bv_after, prior_after;
  logic                                    improved_after;
  logic [acs_pkg::STEP_WIDTH-1:0]          step_new;
  logic [acs_pkg::ROUND_COUNT_WIDTH-1:0]   rounds_new;
  logic signed [acs_pkg::VALUE_WIDTH:0]    vdiff;
  logic [acs_pkg::VALUE_WIDTH:0]           vabs;
  acs_pkg::cause_t                         end_cause;
  logic                                    do_begin_y, do_end;
  acs_pkg::kind_t                          kind_nxt;
  acs_pkg::cause_t                         cause_nxt;
  logic                                    advance;

  assign advance = in_valid && (!out_valid_r || out_ready);
  assign in_take = advance;

  acs_step_scale u_step_scale (
    .clk       (clk),
    .step      (step_r),
    .step_up_r (step_up)
  );

  // What the current reply does to the best point
  always_comb begin
    v              = in_item.objective_value;
    better         = (v < best_val_r);
    bx_after       = better ? trial_x_r : best_x_r;
    by_after       = better ? trial_y_r : best_y_r;
    bv_after       = better ? v : best_val_r;
    prior_after    = better ? best_val_r : prior_r;
    improved_after = improved_r || better;
  end

  // Round end: new step, round count and stop test
  always_comb begin
    step_new   = improved_after ? step_up : (step_r >> 1);
    rounds_new = (rounds_r == {acs_pkg::ROUND_COUNT_WIDTH{1'b1}}) ? rounds_r
                                                                   : rounds_r + 1'b1;
    vdiff = {bv_after[acs_pkg::VALUE_WIDTH-1], bv_after} -
            {prior_after[acs_pkg::VALUE_WIDTH-1], prior_after};
    vabs  = vdiff[acs_pkg::VALUE_WIDTH] ? $unsigned(-vdiff) : $unsigned(vdiff);
    if (step_new < cfg.minimum_step) begin
      end_cause = acs_pkg::CAUSE_MIN_STEP;
    end else if (vabs < {2'b00, cfg.value_tolerance}) begin
      end_cause = acs_pkg::CAUSE_TOLERANCE;
    end else if (rounds_new >= cfg.iteration_limit) begin
      end_cause = acs_pkg::CAUSE_ROUND_LIMIT;
    end else begin
      end_cause = acs_pkg::CAUSE_RUN;
    end
  end

  // Next state and result word
  always_comb begin
    phase_nxt    = phase_r;
    best_x_nxt   = best_x_r;
    best_y_nxt   = best_y_r;
    best_val_nxt = best_val_r;
    prior_nxt    = prior_r;
    trial_x_nxt  = trial_x_r;
    trial_y_nxt  = trial_y_r;
    step_nxt     = step_r;
    rounds_nxt   = rounds_r;
    improved_nxt = improved_r;
    kind_nxt     = acs_pkg::KIND_EVAL;
    cause_nxt    = acs_pkg::CAUSE_RUN;
    do_begin_y   = 1'b0;
    do_end       = 1'b0;

    if (in_item.action == acs_pkg::ACT_START) begin
      best_x_nxt   = in_item.start_x;
      best_y_nxt   = in_item.start_y;
      best_val_nxt = '0;
      prior_nxt    = acs_pkg::VALUE_MIN;
      step_nxt     = cfg.start_step;
      rounds_nxt   = '0;
      improved_nxt = 1'b0;
      trial_x_nxt  = in_item.start_x;
      trial_y_nxt  = in_item.start_y;
      phase_nxt    = PH_START;
    end else begin
      unique case (phase_r)
        PH_START: begin
          best_val_nxt = v;
          if (rounds_r >= cfg.iteration_limit) begin
            kind_nxt  = acs_pkg::KIND_DONE;
            cause_nxt = acs_pkg::CAUSE_ROUND_LIMIT;
            phase_nxt = PH_IDLE;
          end else begin
            improved_nxt = 1'b0;
            trial_x_nxt  = sat_add(best_x_r, step_r);
            trial_y_nxt  = best_y_r;
            phase_nxt    = PH_XP;
          end
        end
        PH_XP: begin
          if (better) begin
            do_begin_y = 1'b1;
          end else begin
            trial_x_nxt = sat_sub(best_x_r, step_r);
            phase_nxt   = PH_XM;
          end
        end
        PH_XM: begin
          do_begin_y = 1'b1;
        end
        PH_YP: begin
          if (better) begin
            do_end = 1'b1;
          end else begin
            trial_y_nxt = sat_sub(best_y_r, step_r);
            phase_nxt   = PH_YM;
          end
        end
        PH_YM: begin
          do_end = 1'b1;
        end
        default: begin
          kind_nxt  = acs_pkg::KIND_IGNORED;
          phase_nxt = PH_IDLE;
        end
      endcase

      // Take an improving trial
      if (do_begin_y || do_end) begin
        best_x_nxt   = bx_after;
        best_y_nxt   = by_after;
        best_val_nxt = bv_after;
        prior_nxt    = prior_after;
        improved_nxt = improved_after;
      end

      // y trials start from the updated best point
      if (do_begin_y) begin
        trial_x_nxt = bx_after;
        trial_y_nxt = sat_add(by_after, step_r);
        phase_nxt   = PH_YP;
      end

      if (do_end) begin
        step_nxt   = step_new;
        rounds_nxt = rounds_new;
        if (end_cause != acs_pkg::CAUSE_RUN) begin
          kind_nxt  = acs_pkg::KIND_DONE;
          cause_nxt = end_cause;
          phase_nxt = PH_IDLE;
        end else begin
          improved_nxt = 1'b0;
          trial_x_nxt  = sat_add(bx_after, step_new);
          trial_y_nxt  = by_after;
          phase_nxt    = PH_XP;
        end
      end
    end

    out_item_nxt.result_kind = kind_nxt;
    out_item_nxt.point_x     = (kind_nxt == acs_pkg::KIND_EVAL) ? trial_x_nxt : best_x_nxt;
    out_item_nxt.point_y     = (kind_nxt == acs_pkg::KIND_EVAL) ? trial_y_nxt : best_y_nxt;
    out_item_nxt.best_value  = best_val_nxt;
    out_item_nxt.rounds_done = rounds_nxt;
    out_item_nxt.stop_cause  = cause_nxt;

    out_valid_nxt = advance ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      best_x_r    <= '0;
      best_y_r    <= '0;
      best_val_r  <= '0;
      rounds_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (advance) begin
        phase_r    <= phase_nxt;
        best_x_r   <= best_x_nxt;
        best_y_r   <= best_y_nxt;
        best_val_r <= best_val_nxt;
        rounds_r   <= rounds_nxt;
      end
    end
    if (advance) begin
      prior_r    <= prior_nxt;
      trial_x_r  <= trial_x_nxt;
      trial_y_r  <= trial_y_nxt;
      step_r     <= step_nxt;
      improved_r <= improved_nxt;
      out_item_r <= out_item_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

[src/acs_checker.sv]
`include "adaptive_compass_search_top_defines.svh"

// Port-level checks of the compass search block
module acs_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tready,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [acs_pkg::OUT_DATA_W-1:0]  out_tdata,
  input logic [1:0]                      out_tuser
);

  logic [1:0] cause;
  logic       running;

  assign cause   = out_tdata[acs_pkg::CAUSE_LSB+1:acs_pkg::CAUSE_LSB];
  assign running = (cause == acs_pkg::CAUSE_RUN);

  // A stalled result word holds
  `ACS_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser), "result word changed while stalled")

  // Input side only backs up when the result side is stalled
  `ACS_ASSERT_NOW(a_in_stall, !in_tready, out_tvalid && !out_tready, "input stalled without output back-pressure")

  // Requests and ignored replies carry no stop cause
  `ACS_ASSERT_NOW(a_cause_run, out_tvalid && (out_tuser != acs_pkg::KIND_DONE), running, "stop cause on a non-final word")

  // A finished word always names why it stopped
  `ACS_ASSERT_NOW(a_cause_done, out_tvalid && (out_tuser == acs_pkg::KIND_DONE), !running, "finished word without stop cause")

endmodule

bind adaptive_compass_search_top acs_checker u_acs_checker (.*);
